@@ rtl/lcls_pkg.sv @@
// Package: shared types and constants for the LED cube layer scanner.
package lcls_pkg;

    localparam int WORD_W        = 10;
    localparam int IDX_W         = 4;
    localparam int CUBE_EDGE_DEF = 10;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  layer_index;
        logic [IDX_W-1:0]  row_index;
        logic [WORD_W-1:0] column_bits;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] shift_word;
        logic [WORD_W-1:0] layer_enable;
        logic              latch_pulse;
        logic              last_word;
    } t_out_word;

endpackage

@@ rtl/led_cube_layer_scanner.sv @@
// A tick makes one frame store read per row; each word passes the read and output registers.
// Throughput: one row word per cycle while i_ready stays high. Reset (synchronous, active
// low) blanks the whole frame store at once through per-entry valid bits and sets the
// layer to zero.
module led_cube_layer_scanner #(
    parameter int CUBE_EDGE = lcls_pkg::CUBE_EDGE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lcls_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output lcls_pkg::t_out_word o_word
);
    import lcls_pkg::*;

    localparam int DEPTH = CUBE_EDGE * CUBE_EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(CUBE_EDGE);
    localparam logic [LW-1:0] LAST_IDX = LW'(CUBE_EDGE - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [LW-1:0]     r_layer;
    logic [LW-1:0]     r_fetch_row;
    logic              r_fetch_done;
    logic              r_rd_vld;
    logic              r_rd_hit;
    logic [LW-1:0]     r_rd_row;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_out_vld;
    t_out_word         r_out;
    logic [DEPTH-1:0]  r_vld;
    logic [WORD_W-1:0] r_mem [DEPTH];

    logic          w_accept;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_load_out;
    logic          w_issue;
    logic          w_out_take;
    logic          w_rd_last;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_vld;
    assign o_word     = r_out;
    assign w_accept   = i_valid && o_ready;
    assign w_wr_en    = w_accept && (i_word.command == CMD_WRITE)
                        && ({1'b0, i_word.layer_index} < (IDX_W+1)'(CUBE_EDGE))
                        && ({1'b0, i_word.row_index} < (IDX_W+1)'(CUBE_EDGE));
    assign w_wr_addr  = AW'(i_word.layer_index) * AW'(CUBE_EDGE) + AW'(i_word.row_index);
    assign w_rd_addr  = AW'(r_layer) * AW'(CUBE_EDGE) + AW'(r_fetch_row);
    assign w_out_take = r_out_vld && i_ready;
    assign w_load_out = r_rd_vld && (!r_out_vld || i_ready);
    assign w_issue    = (r_state == S_RUN) && !r_fetch_done && (!r_rd_vld || w_load_out);
    assign w_rd_last  = (r_rd_row == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_word.column_bits;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_hit  <= r_vld[w_rd_addr];
            r_rd_row  <= r_fetch_row;
        end
        if (w_load_out) begin
            r_out.shift_word   <= r_rd_hit ? r_rd_data : '0;
            r_out.layer_enable <= w_rd_last ? (WORD_W'(1) << r_layer) : '0;
            r_out.latch_pulse  <= w_rd_last;
            r_out.last_word    <= w_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_layer      <= '0;
            r_fetch_row  <= '0;
            r_fetch_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_vld        <= '0;
        end else begin
            if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (w_issue) begin
                r_rd_vld <= 1'b1;
            end else if (w_load_out) begin
                r_rd_vld <= 1'b0;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (w_out_take) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_word.command == CMD_TICK)) begin
                        r_state      <= S_RUN;
                        r_fetch_row  <= '0;
                        r_fetch_done <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (w_issue) begin
                        if (r_fetch_row == LAST_IDX) begin
                            r_fetch_done <= 1'b1;
                        end else begin
                            r_fetch_row <= r_fetch_row + 1'b1;
                        end
                    end
                    if (w_out_take && r_out.last_word) begin
                        r_state <= S_IDLE;
                        r_layer <= (r_layer == LAST_IDX) ? '0 : r_layer + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("output word pending while idle");
    a_enable_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.last_word) |-> (o_word.layer_enable == '0))
        else $error("layer enable before last word");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_word.last_word) |=> (o_ready && !o_valid))
        else $error("tick not finished after last word");
    a_layer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_layer <= LAST_IDX)
        else $error("layer counter out of range");
    a_layer_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && $past(r_state) == S_RUN) |-> $stable(r_layer))
        else $error("layer changed during a tick");
`endif

endmodule
